[rtl/core/lru_keyed_handle_cache_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed handle cache
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_HANDLE_CACHE_CORE_DEFINES_SVH
`define LRU_KEYED_HANDLE_CACHE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LKHC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkhc assertion failed");
// Next-cycle implication.
`define LKHC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkhc assertion failed");
`else
`define LKHC_ASSERT_IMP(name, clk, rst, ante, cons)
`define LKHC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/core/lkhc_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed handle cache package
// Field widths, command codes, beat payload types and defaults.
// ----------------------------------------------------------------------------
package lkhc_pkg;

  localparam int CMD_W        = 2;
  localparam int KEY_W        = 64;
  localparam int REF_W        = 32;
  localparam int SLOT_FIELD_W = 3;

  localparam int SLOTS_DEF       = 8;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] lookup_key;
    logic [REF_W-1:0] new_plan;
    logic [REF_W-1:0] new_spline;
    logic [REF_W-1:0] new_accel;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic                    displaced;
    logic [SLOT_FIELD_W-1:0] slot_used;
    logic [REF_W-1:0]        plan_ref;
    logic [REF_W-1:0]        spline_ref;
    logic [REF_W-1:0]        accel_ref;
  } rsp_t;

  // Decision of the directory for one request.
  typedef struct packed {
    logic                    hit;
    logic                    displaced;
    logic                    refs_ok;
    logic [SLOT_FIELD_W-1:0] slot_field;
  } pick_t;

endpackage

[rtl/core/lkhc_stream_if.sv]
// ----------------------------------------------------------------------------
// Keyed handle cache stream interface
// Valid/ready channel that carries one payload per beat.
// ----------------------------------------------------------------------------
interface lkhc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/core/lkhc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lkhc_dir.sv]
// ----------------------------------------------------------------------------
// Keyed handle cache directory
// Slot valid bits, stored keys and recency ranks; picks the slot for a request.
// ----------------------------------------------------------------------------
`include "lru_keyed_handle_cache_core_defines.svh"

module lkhc_dir import lkhc_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [KEY_BITS-1:0]      key,
  output pick_t                    pick,
  output logic [$clog2(SLOTS)-1:0] slot
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int RANK_W = $clog2(SLOTS);
  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(SLOTS - 1);

  logic [SLOTS-1:0]    valid;
  logic [KEY_BITS-1:0] keys [SLOTS];
  logic [RANK_W-1:0]   rank [SLOTS];
  logic [RANK_W-1:0]   rank_next [SLOTS];

  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  oldest;
  logic              any_hit;
  logic              any_free;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] lru_idx;
  logic [SLOT_W-1:0] target;
  logic              was_valid;
  logic [RANK_W-1:0] rank_sel;
  logic [SLOT_W+SLOT_FIELD_W-1:0] slot_wide;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    // Descending scans, so the lowest-numbered candidate wins.
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i]  = valid[i] && (keys[i] == key);
      oldest[i] = (rank[i] == RANK_LAST);
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!valid[i]) begin
        free_idx = SLOT_W'(i);
      end
      if (oldest[i]) begin
        lru_idx = SLOT_W'(i);
      end
    end
    any_hit  = |match;
    any_free = ~&valid;
    target   = any_free ? free_idx : lru_idx;
  end

  always_comb begin
    pick      = '0;
    slot      = target;
    was_valid = valid[target];
    unique case (cmd)
      CMD_LOOKUP: begin
        slot         = hit_idx;
        was_valid    = 1'b1;
        pick.hit     = any_hit;
        pick.refs_ok = any_hit;
      end
      CMD_INSERT: begin
        pick.displaced = !any_free;
        pick.refs_ok   = !any_free;
      end
      default: begin
      end
    endcase
    slot_wide = {{SLOT_FIELD_W{1'b0}}, slot};
    if ((cmd == CMD_INSERT) || pick.hit) begin
      pick.slot_field = slot_wide[SLOT_FIELD_W-1:0];
    end
  end

  // A slot moved to the front ages newer valid slots; all if it was free.
  always_comb begin
    rank_sel = rank[slot];
    for (int j = 0; j < SLOTS; j++) begin
      if (SLOT_W'(j) == slot) begin
        rank_next[j] = '0;
      end else if (valid[j] && (!was_valid || (rank[j] < rank_sel))) begin
        rank_next[j] = rank[j] + 1'b1;
      end else begin
        rank_next[j] = rank[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int j = 0; j < SLOTS; j++) begin
        rank[j] <= '0;
      end
    end else if (adv) begin
      unique case (cmd)
        CMD_LOOKUP: begin
          if (any_hit) begin
            rank <= rank_next;
          end
        end
        CMD_INSERT: begin
          rank        <= rank_next;
          valid[slot] <= 1'b1;
        end
        CMD_CLEAR: begin
          valid <= '0;
          for (int j = 0; j < SLOTS; j++) begin
            rank[j] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (cmd == CMD_INSERT)) begin
      keys[slot] <= key;
    end
  end

  `LKHC_ASSERT_IMP(a_full_one_oldest, clk, rst, &valid, $onehot(oldest))
  `LKHC_ASSERT_NXT(a_clear_empties, clk, rst, adv && (cmd == CMD_CLEAR), valid == '0)
  `LKHC_ASSERT_NXT(a_insert_fills, clk, rst, adv && (cmd == CMD_INSERT), valid[$past(slot)])

endmodule

[rtl/core/lru_keyed_handle_cache_core.sv]
// ----------------------------------------------------------------------------
// Keyed handle cache core
// Fully associative cache with least-recently-used replacement; each slot
// holds a key and three handles.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload  Contents
//   req      in   req_t    cmd, lookup_key, new_plan, new_spline, new_accel
//   rsp      out  rsp_t    hit, displaced, slot_used, plan/spline/accel_ref
//
// One request per cycle while the result stream keeps taking beats; a request
// beat is taken into the input register, the key compare and rank update run
// on it, and the result register and the handle RAM read port capture when the
// result stage has room; the result beat is offered from those registers.
// Reset clears the valid bits and ranks at once; no clearing pass follows.
// A stalled result holds the pipeline while the input register takes one beat.
// ----------------------------------------------------------------------------
`include "lru_keyed_handle_cache_core_defines.svh"

module lru_keyed_handle_cache_core import lkhc_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  lkhc_stream_if.sink   req,
  lkhc_stream_if.source rsp
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ENTRY_W = 3 * HANDLE_BITS;

  req_t  req_q;
  logic  v1;
  logic  v2;
  pick_t pick;
  pick_t pick_q;
  logic  adv;

  logic [SLOT_W-1:0]  slot;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;

  logic [HANDLE_BITS+REF_W-1:0] in_plan_w;
  logic [HANDLE_BITS+REF_W-1:0] in_spline_w;
  logic [HANDLE_BITS+REF_W-1:0] in_accel_w;
  logic [HANDLE_BITS+REF_W-1:0] out_plan_w;
  logic [HANDLE_BITS+REF_W-1:0] out_spline_w;
  logic [HANDLE_BITS+REF_W-1:0] out_accel_w;

  assign adv       = v1 && (!v2 || rsp.ready);
  assign req.ready = !v1 || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (req.ready) begin
        v1 <= req.valid;
      end
      if (!v2 || rsp.ready) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req.payload;
    end
    if (adv) begin
      pick_q <= pick;
    end
  end

  lkhc_dir #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dir (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cmd  (req_q.cmd),
    .key  (req_q.lookup_key[KEY_BITS-1:0]),
    .pick (pick),
    .slot (slot)
  );

  assign in_plan_w   = {{HANDLE_BITS{1'b0}}, req_q.new_plan};
  assign in_spline_w = {{HANDLE_BITS{1'b0}}, req_q.new_spline};
  assign in_accel_w  = {{HANDLE_BITS{1'b0}}, req_q.new_accel};
  assign wdata = {in_plan_w[HANDLE_BITS-1:0], in_spline_w[HANDLE_BITS-1:0],
                  in_accel_w[HANDLE_BITS-1:0]};

  // The insert reads the victim's old handles in the cycle it overwrites them.
  lkhc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_handles (
    .clk   (clk),
    .we    (adv && (req_q.cmd == CMD_INSERT)),
    .waddr (slot),
    .wdata (wdata),
    .re    (adv),
    .raddr (slot),
    .rdata (rdata)
  );

  assign out_plan_w   = {{REF_W{1'b0}}, rdata[3*HANDLE_BITS-1:2*HANDLE_BITS]};
  assign out_spline_w = {{REF_W{1'b0}}, rdata[2*HANDLE_BITS-1:HANDLE_BITS]};
  assign out_accel_w  = {{REF_W{1'b0}}, rdata[HANDLE_BITS-1:0]};

  always_comb begin
    rsp.valid              = v2;
    rsp.payload.hit        = pick_q.hit;
    rsp.payload.displaced  = pick_q.displaced;
    rsp.payload.slot_used  = pick_q.slot_field;
    rsp.payload.plan_ref   = '0;
    rsp.payload.spline_ref = '0;
    rsp.payload.accel_ref  = '0;
    if (pick_q.refs_ok) begin
      rsp.payload.plan_ref   = out_plan_w[REF_W-1:0];
      rsp.payload.spline_ref = out_spline_w[REF_W-1:0];
      rsp.payload.accel_ref  = out_accel_w[REF_W-1:0];
    end
  end

  `LKHC_ASSERT_IMP(a_hit_not_displaced, clk, rst, v2, !(pick_q.hit && pick_q.displaced))
  `LKHC_ASSERT_IMP(a_full_take_moves, clk, rst, req.valid && req.ready && v1, adv)
  `LKHC_ASSERT_NXT(a_adv_fills_out, clk, rst, adv, v2)

endmodule

[tb/lru_keyed_handle_cache_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed handle cache core testbench
// Drives lookups, inserts, clears and the unused command code through the
// request stream, with random idle cycles on both streams. A scoreboard
// carries its own copy of the slot directory and LRU ranks and compares each
// result beat with the answer it predicts.
// ----------------------------------------------------------------------------
module lru_keyed_handle_cache_core_tb;
  import lkhc_pkg::*;

  localparam int          NUM_SLOTS   = SLOTS_DEF;
  localparam int          POOL_SIZE   = 16;
  localparam int          PHASE_ITEMS = 210;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          REPORT_MAX  = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class handle_cache_scoreboard;
    bit                   slot_live   [NUM_SLOTS];
    logic [KEY_W-1:0]     slot_key    [NUM_SLOTS];
    logic [REF_W-1:0]     slot_plan   [NUM_SLOTS];
    logic [REF_W-1:0]     slot_spline [NUM_SLOTS];
    logic [REF_W-1:0]     slot_accel  [NUM_SLOTS];
    int unsigned          slot_age    [NUM_SLOTS];
    rsp_t                 awaited_answers[$];
    int                   mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
    endfunction

    // Ages count the valid slots used more recently; a slot that was already
    // valid only pushes back the slots that were younger than it.
    function void promote_slot(int s, bit was_live);
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j != s && slot_live[j] && (!was_live || slot_age[j] < slot_age[s]))
          slot_age[j]++;
      end
      slot_age[s] = 0;
    endfunction

    function rsp_t resolve_request(req_t r);
      rsp_t ans;
      int   tgt;
      bit   found;
      bit   was_live;
      ans   = '0;
      tgt   = 0;
      found = 1'b0;
      case (r.cmd)
        CMD_LOOKUP: begin
          for (int i = 0; i < NUM_SLOTS && !found; i++) begin
            if (slot_live[i] && slot_key[i] == r.lookup_key) begin
              found = 1'b1;
              tgt   = i;
            end
          end
          if (found) begin
            promote_slot(tgt, 1'b1);
            ans.hit        = 1'b1;
            ans.slot_used  = tgt[SLOT_FIELD_W-1:0];
            ans.plan_ref   = slot_plan[tgt];
            ans.spline_ref = slot_spline[tgt];
            ans.accel_ref  = slot_accel[tgt];
          end
        end
        CMD_INSERT: begin
          for (int i = 0; i < NUM_SLOTS && !found; i++) begin
            if (!slot_live[i]) begin
              found = 1'b1;
              tgt   = i;
            end
          end
          if (!found) begin
            for (int i = 1; i < NUM_SLOTS; i++)
              if (slot_age[i] > slot_age[tgt]) tgt = i;
          end
          was_live = slot_live[tgt];
          if (was_live) begin
            ans.displaced  = 1'b1;
            ans.plan_ref   = slot_plan[tgt];
            ans.spline_ref = slot_spline[tgt];
            ans.accel_ref  = slot_accel[tgt];
          end
          ans.slot_used = tgt[SLOT_FIELD_W-1:0];
          promote_slot(tgt, was_live);
          slot_key[tgt]    = r.lookup_key;
          slot_plan[tgt]   = r.new_plan;
          slot_spline[tgt] = r.new_spline;
          slot_accel[tgt]  = r.new_accel;
          slot_live[tgt]   = 1'b1;
        end
        CMD_CLEAR: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
          end
        end
        default: begin
        end
      endcase
      return ans;
    endfunction

    function void note_request(req_t r);
      awaited_answers.insert(awaited_answers.size(), resolve_request(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      bit   bad;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result beat: %p", got);
        return;
      end
      want = awaited_answers.pop_front();
      bad  = (want.hit !== got.hit) || (want.displaced !== got.displaced) ||
             (want.slot_used !== got.slot_used) || (want.plan_ref !== got.plan_ref) ||
             (want.spline_ref !== got.spline_ref) || (want.accel_ref !== got.accel_ref);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected hit=%0b displaced=%0b slot=%0d plan=%h spline=%h accel=%h",
                   want.hit, want.displaced, want.slot_used, want.plan_ref,
                   want.spline_ref, want.accel_ref);
          $display("  actual   hit=%0b displaced=%0b slot=%0d plan=%h spline=%h accel=%h",
                   got.hit, got.displaced, got.slot_used, got.plan_ref,
                   got.spline_ref, got.accel_ref);
        end
      end
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lkhc_stream_if #(.payload_t(req_t)) req_if ();
  lkhc_stream_if #(.payload_t(rsp_t)) rsp_if ();

  lru_keyed_handle_cache_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  handle_cache_scoreboard sb;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     quiet_cycles;
  logic [KEY_W-1:0]       key_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    quiet_cycles   = 0;
    sb = new();
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) rsp_if.ready = 1'b0;
    else     rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Requests are noted before results are checked, so the queue order holds
  // whatever the pipeline depth is.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                    logic [REF_W-1:0] p, logic [REF_W-1:0] s,
                                    logic [REF_W-1:0] a);
    req_t r;
    r.cmd        = c;
    r.lookup_key = k;
    r.new_plan   = p;
    r.new_spline = s;
    r.new_accel  = a;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic push_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.payload = r;
    req_if.valid   = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Keys mostly come from a small pool so that lookups hit and inserts
  // revisit keys already cached; the pool slowly picks up fresh keys.
  function automatic req_t random_req();
    int               pick;
    int               idx;
    logic [KEY_W-1:0] k;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(0, 99);
    idx  = $urandom_range(0, POOL_SIZE - 1);
    if ($urandom_range(0, 19) == 0) key_pool[idx] = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 85) k = key_pool[idx];
    else                            k = {$urandom, $urandom};
    if (pick < 50)      c = CMD_LOOKUP;
    else if (pick < 93) c = CMD_INSERT;
    else if (pick < 97) c = CMD_CLEAR;
    else                c = CMD_UNUSED;
    return make_req(c, k, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    logic [KEY_W-1:0] fill_keys [NUM_SLOTS];
    fill_keys[0] = '0;
    fill_keys[1] = '1;
    fill_keys[2] = 64'h5555_5555_5555_5555;
    fill_keys[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    fill_keys[4] = 64'h8000_0000_0000_0001;
    fill_keys[5] = 64'h7FFF_FFFF_FFFF_FFFE;
    fill_keys[6] = {$urandom, $urandom};
    fill_keys[7] = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: miss on an empty cache, fill every slot, hits, LRU eviction,
    // a duplicate key, the unused code, clear and reuse after clear.
    push_request(make_req(CMD_LOOKUP, '1, '1, '1, '1));
    push_request(make_req(CMD_INSERT, fill_keys[0], '0, '0, '0));
    push_request(make_req(CMD_INSERT, fill_keys[1], '1, '1, '1));
    push_request(make_req(CMD_INSERT, fill_keys[2], 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h8000_0001));
    push_request(make_req(CMD_INSERT, fill_keys[3], 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h7FFF_FFFE));
    for (int i = 4; i < NUM_SLOTS; i++)
      push_request(make_req(CMD_INSERT, fill_keys[i], $urandom, $urandom, $urandom));
    push_request(make_req(CMD_LOOKUP, fill_keys[0], '0, '0, '0));
    push_request(make_req(CMD_LOOKUP, fill_keys[1], '0, '0, '0));
    push_request(make_req(CMD_INSERT, 64'h0123_4567_89AB_CDEF, $urandom, $urandom,
                          $urandom));
    push_request(make_req(CMD_INSERT, fill_keys[1], $urandom, $urandom, $urandom));
    push_request(make_req(CMD_LOOKUP, fill_keys[1], '0, '0, '0));
    push_request(make_req(CMD_LOOKUP, 64'h0000_0000_0000_1234, '0, '0, '0));
    push_request(make_req(CMD_UNUSED, fill_keys[0], '1, '1, '1));
    push_request(make_req(CMD_CLEAR, '1, '1, '1, '1));
    push_request(make_req(CMD_LOOKUP, fill_keys[0], '0, '0, '0));
    push_request(make_req(CMD_INSERT, fill_keys[5], $urandom, $urandom, $urandom));

    send_idle_pct = 35;
    recv_idle_pct = 63;
    repeat (PHASE_ITEMS) push_request(random_req());
    send_idle_pct = 63;
    recv_idle_pct = 35;
    repeat (PHASE_ITEMS) push_request(random_req());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) push_request(random_req());
    req_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
